>>> rtl/ggm_pkg.sv
// Package for the granular grain mixer: sizes, opcodes, command and status types.
// Used by every module of the block except ggm_ram; depends on nothing.
package ggm_pkg;
	localparam int SLOTS = 16;
	localparam int MAX_GRAIN = 1024;
	localparam int SOURCE_DEPTH = 4096;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int GOFF_W = $clog2(MAX_GRAIN);
	localparam int SRC_W = $clog2(SOURCE_DEPTH);
	localparam int GADDR_W = SLOT_W + GOFF_W;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_WR_SRC = 2'd1;
	localparam logic [1:0] OP_WR_ENV = 2'd2;
	localparam logic [1:0] OP_START = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [11:0] index;
		logic signed [15:0] sample_value;
		logic [11:0] start_position;
		logic [10:0] grain_length;
	} in_item_t;

	typedef struct packed {
		logic result_kind;
		logic signed [23:0] mix_sample;
		logic start_status;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic wr_src;
		logic wr_env;
		logic mod_step;
		logic start_init;
		logic copy_rd;
		logic copy_wr;
		logic copy_done;
		logic tick_clr;
		logic tick_rd;
		logic tick_acc;
		logic tick_adv;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic len_bad;
		logic mod_done;
		logic free_found;
		logic [SLOT_W-1:0] free_slot;
		logic copy_last;
		logic active;
		logic signed [23:0] mix;
	} status_t;
endpackage

>>> rtl/ggm_if.sv
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on ggm_pkg.
interface ggm_in_if import ggm_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ggm_out_if import ggm_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/ggm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ggm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/ggm_datapath.sv
// Datapath: stores, slot registers, modulo reduction, envelope multiply, mix sum.
// Depends on ggm_pkg and ggm_ram.
module ggm_datapath import ggm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [12:0] cfg_wdata,
	input in_item_t in_data,
	input cmd_t cmd,
	output status_t sts
);
	in_item_t item_q;
	logic [12:0] slen_q;
	logic [12:0] ulen;
	logic [12:0] pos_q;
	logic [GOFF_W:0] cnt_q;
	logic [GOFF_W-1:0] wcnt_q;
	logic [SLOT_W-1:0] slot_q;
	logic slot_active_q [SLOTS];
	logic [GOFF_W:0] slot_offset_q [SLOTS];
	logic [GOFF_W:0] slot_length_q [SLOTS];
	logic signed [15:0] src_rd, env_rd, grn_rd;
	logic signed [31:0] prod_s1;
	logic signed [16:0] rnd;
	logic signed [15:0] shaped;
	logic signed [24:0] acc_q;
	logic [GADDR_W-1:0] grn_raddr;
	logic [GOFF_W:0] off_nx;
	logic env_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slen_q <= 13'(SOURCE_DEPTH);
		else if (cfg_we) slen_q <= cfg_wdata;
	end

	always_comb begin
		if (slen_q == 13'd0) ulen = 13'd1;
		else if (slen_q > 13'(SOURCE_DEPTH)) ulen = 13'(SOURCE_DEPTH);
		else ulen = slen_q;
	end

	assign env_we = cmd.wr_env && (item_q.index < 12'(MAX_GRAIN));

	ggm_ram #(.WIDTH(16), .DEPTH(SOURCE_DEPTH)) u_src (
		.clk(clk), .we(cmd.wr_src), .waddr(item_q.index[SRC_W-1:0]),
		.wdata(item_q.sample_value), .raddr(pos_q[SRC_W-1:0]), .rdata(src_rd));
	ggm_ram #(.WIDTH(16), .DEPTH(MAX_GRAIN)) u_env (
		.clk(clk), .we(env_we), .waddr(item_q.index[GOFF_W-1:0]),
		.wdata(item_q.sample_value), .raddr(cnt_q[GOFF_W-1:0]), .rdata(env_rd));

	assign rnd = 17'(prod_s1 + 32'sd16384 >>> 15);
	always_comb begin
		if (rnd > 17'sd32767) shaped = 16'sh7fff;
		else if (rnd < -17'sd32768) shaped = 16'sh8000;
		else shaped = rnd[15:0];
	end

	assign grn_raddr = {cmd.slot, slot_offset_q[cmd.slot][GOFF_W-1:0]};
	ggm_ram #(.WIDTH(16), .DEPTH(SLOTS*MAX_GRAIN)) u_grn (
		.clk(clk), .we(cmd.copy_wr), .waddr({slot_q, wcnt_q}),
		.wdata(shaped), .raddr(grn_raddr), .rdata(grn_rd));

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		prod_s1 <= src_rd * env_rd;
		if (cmd.start_init) begin
			pos_q <= {1'b0, item_q.start_position};
			cnt_q <= '0;
			wcnt_q <= '0;
			slot_q <= sts.free_slot;
		end else if (cmd.mod_step) begin
			if (pos_q >= ulen) pos_q <= pos_q - ulen;
		end else if (cmd.copy_rd) begin
			cnt_q <= cnt_q + 1'b1;
			pos_q <= (pos_q + 13'd1 >= ulen) ? 13'd0 : pos_q + 13'd1;
		end
		if (cmd.copy_wr) wcnt_q <= wcnt_q + 1'b1;
		if (cmd.tick_clr) acc_q <= '0;
		else if (cmd.tick_acc) acc_q <= acc_q + 25'(grn_rd);
	end

	assign off_nx = slot_offset_q[cmd.slot] + 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_active_q[i] <= 1'b0;
				slot_offset_q[i] <= '0;
				slot_length_q[i] <= '0;
			end
		end else if (cmd.copy_done) begin
			slot_active_q[slot_q] <= 1'b1;
			slot_offset_q[slot_q] <= '0;
			slot_length_q[slot_q] <= item_q.grain_length[GOFF_W:0];
		end else if (cmd.tick_adv && slot_active_q[cmd.slot]) begin
			if (off_nx >= slot_length_q[cmd.slot]) begin
				slot_active_q[cmd.slot] <= 1'b0;
				slot_offset_q[cmd.slot] <= '0;
				slot_length_q[cmd.slot] <= '0;
			end else begin
				slot_offset_q[cmd.slot] <= off_nx;
			end
		end
	end

	always_comb begin
		sts.opcode = item_q.opcode;
		sts.len_bad = (item_q.grain_length == 11'd0) ||
			(item_q.grain_length > 11'(MAX_GRAIN));
		sts.mod_done = pos_q < ulen;
		sts.free_found = 1'b0;
		sts.free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_active_q[i]) begin
				sts.free_found = 1'b1;
				sts.free_slot = SLOT_W'(i);
			end
		end
		sts.copy_last = cnt_q + 1'b1 == item_q.grain_length[GOFF_W:0];
		sts.active = slot_active_q[cmd.slot];
		if (acc_q > 25'sd8388607) sts.mix = 24'sh7fffff;
		else if (acc_q < -25'sd8388608) sts.mix = 24'sh800000;
		else sts.mix = acc_q[23:0];
	end
endmodule

>>> rtl/ggm_ctrl.sv
// Controller state machine that sequences writes, grain copies and ticks.
// Depends on ggm_pkg and ggm_if.
module ggm_ctrl import ggm_pkg::*; (
	input logic clk,
	input logic arst_n,
	ggm_in_if.sink in_ch,
	ggm_out_if.source out_ch,
	input status_t sts,
	output cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_MOD, S_FIND, S_CRD, S_CDRAIN, S_TICK, S_TDRAIN, S_OUT
	} state_t;
	state_t state_q;
	logic [SLOT_W-1:0] slot_q;
	logic [2:0] pipe_q;
	logic [1:0] tpipe_q;
	logic last_q;
	logic rd_slot;

	assign in_ch.ready = (state_q == S_IDLE) && !out_ch.valid;

	always_comb begin
		cmd = '0;
		cmd.load = in_ch.valid && in_ch.ready;
		cmd.slot = slot_q;
		rd_slot = 1'b0;
		case (state_q)
			S_DECODE: begin
				cmd.wr_src = sts.opcode == OP_WR_SRC;
				cmd.wr_env = sts.opcode == OP_WR_ENV;
				cmd.tick_clr = sts.opcode == OP_TICK;
			end
			S_FIND: cmd.start_init = !sts.len_bad && sts.free_found;
			S_MOD: cmd.mod_step = 1'b1;
			S_CRD: cmd.copy_rd = !last_q;
			default: ;
		endcase
		// Products are written after the read has passed the RAM output register and the multiply register.
		cmd.copy_wr = pipe_q[1];
		cmd.copy_done = (state_q == S_CDRAIN) && pipe_q == 3'b000;
		if (state_q == S_TICK) rd_slot = 1'b1;
		cmd.tick_adv = rd_slot;
		cmd.tick_acc = tpipe_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q <= '0;
			pipe_q <= '0;
			tpipe_q <= '0;
			last_q <= 1'b0;
			out_ch.valid <= 1'b0;
			out_ch.data <= '0;
		end else begin
			pipe_q <= {pipe_q[1:0], cmd.copy_rd};
			tpipe_q <= {tpipe_q[0], rd_slot && sts.active};
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_DECODE;
				S_DECODE: begin
					slot_q <= '0;
					case (sts.opcode)
						OP_TICK: state_q <= S_TICK;
						OP_START: state_q <= S_FIND;
						default: state_q <= S_IDLE;
					endcase
				end
				S_FIND: begin
					if (sts.len_bad || !sts.free_found) begin
						out_ch.data <= '{result_kind: 1'b1, mix_sample: '0,
							start_status: 1'b1};
						state_q <= S_OUT;
					end else state_q <= S_MOD;
				end
				S_MOD: if (sts.mod_done) begin
					last_q <= 1'b0;
					state_q <= S_CRD;
				end
				S_CRD: begin
					if (!last_q && sts.copy_last) last_q <= 1'b1;
					if (last_q) state_q <= S_CDRAIN;
				end
				S_CDRAIN: if (pipe_q == 3'b000) begin
					out_ch.data <= '{result_kind: 1'b1, mix_sample: '0,
						start_status: 1'b0};
					state_q <= S_OUT;
				end
				S_TICK: begin
					slot_q <= slot_q + 1'b1;
					if (slot_q == SLOT_W'(SLOTS - 1)) state_q <= S_TDRAIN;
				end
				S_TDRAIN: if (tpipe_q == 2'b00 && !rd_slot) begin
					out_ch.data <= '{result_kind: 1'b0, mix_sample: sts.mix,
						start_status: 1'b0};
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_ch.valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/granular_grain_mixer.sv
// Top level of the granular grain mixer: controller plus datapath.
// Depends on ggm_pkg, ggm_if, ggm_ctrl, ggm_datapath.
// Usage: items arrive on in_ch (valid/ready); a transaction is taken when both
// are high. Source and envelope writes give no result; the next item can be
// taken once the controller has gone from its decode state back to idle.
// A start item gives one status result. An accepted grain copies its samples
// one per cycle through the source/envelope memory reads and the registered
// multiplier, after its start position has been reduced by repeated
// subtraction of source_length; its result follows the copy. A discarded
// grain gives its result without a copy.
// A tick visits every slot once, one per cycle through the grain memory read
// port, and shows its mix once the last slot has been summed.
// Results leave on out_ch from an output register; while the receiver stalls
// the result is held and no new item is taken.
// cfg_we/cfg_wdata write source_length; write it only while idle.
// Reset clears all slots and sets source_length to 4096; the sample memories
// keep their contents and must be written before use.
module granular_grain_mixer import ggm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [12:0] cfg_wdata,
	ggm_in_if.sink in_ch,
	ggm_out_if.source out_ch
);
	cmd_t cmd;
	status_t sts;

	ggm_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.sts(sts), .cmd(cmd));
	ggm_datapath u_dp (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .in_data(in_ch.data), .cmd(cmd), .sts(sts));
endmodule

>>> rtl/ggm_checker.sv
// Port-level checker for the granular grain mixer, bound to the top level.
// Depends on ggm_pkg.
module ggm_checker import ggm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind |-> out_data.mix_sample == 24'd0)
		else $error("status result carries a mix value");
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.result_kind |-> !out_data.start_status)
		else $error("mix result carries a status");
endmodule

bind granular_grain_mixer ggm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data));

>>> tb/sv/granular_grain_mixer_test.sv
// Self-checking testbench for the granular grain mixer: drives write, start and tick
// transactions with random gaps and stalls, predicts every result and compares it.
// Depends on ggm_pkg, ggm_if and granular_grain_mixer.
`timescale 1ns / 1ps
module granular_grain_mixer_test;
	import ggm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;

	ggm_in_if in_ch();
	ggm_out_if out_ch();

	granular_grain_mixer dut(.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source));

	always #4 clk = ~clk;

	logic signed [15:0] src_mem [SOURCE_DEPTH];
	logic signed [15:0] env_mem [MAX_GRAIN];
	logic signed [15:0] grain_mem [SLOTS][MAX_GRAIN];
	bit live [SLOTS];
	int unsigned play_pos [SLOTS];
	int unsigned play_len [SLOTS];
	int unsigned src_len = 4096;
	bit src_written [SOURCE_DEPTH];
	bit env_written [MAX_GRAIN];

	in_item_t pending_items[$];
	out_item_t awaited_results[$];
	int mismatches = 0;

	function automatic logic signed [15:0] shaped(logic signed [15:0] s, logic signed [15:0] e);
		longint q;
		q = (longint'(s) * longint'(e) + 16384) >>> 15;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic out_item_t mixer_predict(in_item_t it);
		out_item_t r;
		int unsigned slen, pos, len, s;
		longint acc;
		r = '0;
		case (it.opcode)
			OP_WR_SRC: src_mem[it.index] = it.sample_value;
			OP_WR_ENV: if (it.index < MAX_GRAIN) env_mem[it.index] = it.sample_value;
			OP_START: begin
				r.result_kind = 1'b1;
				slen = (src_len == 0) ? 1 : (src_len > SOURCE_DEPTH ? SOURCE_DEPTH : src_len);
				pos = it.start_position % slen;
				len = it.grain_length;
				r.start_status = 1'b1;
				if (len != 0 && len <= MAX_GRAIN) begin
					for (s = 0; s < SLOTS; s++) if (!live[s]) break;
					if (s < SLOTS) begin
						for (int i = 0; i < len; i++) begin
							grain_mem[s][i] = shaped(src_mem[pos], env_mem[i]);
							pos++;
							if (pos >= slen) pos = 0;
						end
						live[s] = 1;
						play_pos[s] = 0;
						play_len[s] = len;
						r.start_status = 1'b0;
					end
				end
			end
			default: begin
				acc = 0;
				for (int k = 0; k < SLOTS; k++) if (live[k]) begin
					acc += grain_mem[k][play_pos[k]];
					play_pos[k]++;
					if (play_pos[k] >= play_len[k]) begin
						live[k] = 0;
						play_pos[k] = 0;
					end
				end
				if (acc > 8388607) acc = 8388607;
				if (acc < -8388608) acc = -8388608;
				r.mix_sample = acc[23:0];
			end
		endcase
		return r;
	endfunction

	// Driver: one transaction at a time from the pending queue, random gap before each.
	int gap = 0;
	in_item_t cur;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				cur = in_ch.data;
				if (cur.opcode != OP_WR_SRC && cur.opcode != OP_WR_ENV)
					awaited_results.push_back(mixer_predict(cur));
				else
					void'(mixer_predict(cur));
				in_ch.valid <= 1'b0;
				gap = $urandom_range(0, 6);
			end else if (!in_ch.valid) begin
				if (gap > 0) gap--;
				else if (pending_items.size() > 0) begin
					in_ch.data <= pending_items.pop_front();
					in_ch.valid <= 1'b1;
				end
			end
		end
	end

	// Monitor: compares each result transaction with the oldest prediction.
	int stall = 0;
	out_item_t exp_r;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
				end else begin
					exp_r = awaited_results.pop_front();
					if (out_ch.data.result_kind !== exp_r.result_kind ||
							out_ch.data.mix_sample !== exp_r.mix_sample ||
							out_ch.data.start_status !== exp_r.start_status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", exp_r, out_ch.data);
					end
				end
				out_ch.ready <= 1'b0;
				stall = $urandom_range(0, 6);
			end else if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// A start is preceded by writes of every source and envelope entry that it reads.
	task automatic push(logic [1:0] op, int idx, int val, int pos, int len);
		in_item_t it;
		in_item_t wr;
		int unsigned slen, p;
		it.opcode = op;
		it.index = 12'(idx);
		it.sample_value = 16'(val);
		it.start_position = 12'(pos);
		it.grain_length = 11'(len);
		if (op == OP_START && it.grain_length >= 11'd1 &&
				it.grain_length <= 11'(MAX_GRAIN)) begin
			slen = (src_len == 0) ? 1 : (src_len > SOURCE_DEPTH ? SOURCE_DEPTH : src_len);
			p = it.start_position % slen;
			wr = '0;
			for (int i = 0; i < it.grain_length; i++) begin
				if (!src_written[p]) begin
					wr.opcode = OP_WR_SRC;
					wr.index = 12'(p);
					wr.sample_value = (p % 3 == 0) ? 16'sh8000 :
						((p % 3 == 1) ? 16'sh7fff : 16'($urandom));
					pending_items.push_back(wr);
					src_written[p] = 1;
				end
				p++;
				if (p >= slen) p = 0;
				if (!env_written[i]) begin
					wr.opcode = OP_WR_ENV;
					wr.index = 12'(i);
					wr.sample_value = (i % 4 == 0) ? 16'sh8000 : 16'($urandom);
					pending_items.push_back(wr);
					env_written[i] = 1;
				end
			end
		end
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_ch.valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	task automatic set_len(int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 13'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		src_len = v;
	endtask

	task automatic random_phase(int n);
		int op;
		for (int k = 0; k < n; k++) begin
			op = $urandom_range(0, 9);
			if (op < 5) push(OP_TICK, $urandom, $urandom, $urandom, $urandom);
			else if (op < 7) push(OP_WR_SRC, $urandom, $urandom, $urandom, $urandom);
			else if (op < 8) push(OP_WR_ENV, $urandom, $urandom, $urandom, $urandom);
			else if (src_len < 64 && $urandom_range(0, 9) == 0)
				push(OP_START, $urandom, $urandom, $urandom,
					$urandom_range(0, 1) ? $urandom_range(0, 2047) : 1024);
			else
				push(OP_START, $urandom, $urandom, $urandom_range(0, 255),
					$urandom_range(1, 40));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		push(OP_WR_ENV, 4095, 16'h1234, 0, 0);
		push(OP_TICK, 0, 0, 0, 0);
		push(OP_START, 0, 0, 0, 0);
		push(OP_START, 0, 0, 4095, 1025);
		push(OP_START, 0, 0, 2047, 2047);
		push(OP_START, 0, 0, 0, 1);
		for (int i = 0; i < 16; i++) push(OP_START, 0, 0, 3, 3);
		repeat (4) push(OP_TICK, 4095, 16'h7fff, 0, 0);
		wait_idle();
		set_len(1);
		push(OP_START, 0, 0, 4095, 5);
		push(OP_START, 0, 0, 4095, 1024);
		random_phase(150);
		wait_idle();
		set_len(0);
		random_phase(100);
		wait_idle();
		set_len(8191);
		random_phase(100);
		wait_idle();
		set_len(4096);
		random_phase(100);
		wait_idle();
		set_len($urandom_range(2, 50));
		random_phase(200);
		wait_idle();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#40ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
